// ===== hw/rtl/pgsm_pkg.sv =====
package pgsm_pkg;

  // Default coordinate width in bits
  localparam int COORD_BITS_DEFAULT = 16;

  // Depth of the queue between the classifier and the tracker
  localparam int MID_DEPTH_DEFAULT = 4;

  // Depth of the result queue
  localparam int OUT_DEPTH_DEFAULT = 2;

  // Configuration register map
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_X     = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_Y     = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_Z     = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_OFFSET = 8'd3;

  localparam int NORMAL_BITS = 16;
  localparam int OFFSET_BITS = 32;

  // Reset normal is straight up: 1.0 in Q1.14
  localparam logic signed [NORMAL_BITS-1:0] NORMAL_Z_RESET = 16'sd16384;

  // Saturating per-frame counters
  typedef logic [1:0] count_t;
  localparam count_t COUNT_ZERO = 2'd0;
  localparam count_t COUNT_ONE  = 2'd1;
  localparam count_t COUNT_SAT  = 2'd2;

  // Classification flags that travel with a depth through the queue
  typedef struct packed {
    logic kept;
    logic last;
  } flags_t;

  localparam int FLAGS_BITS = $bits(flags_t);

endpackage

// ===== hw/rtl/pgsm_fifo.sv =====
module pgsm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign empty   = (count == '0);
  assign full    = (count == CNT_FULL);
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/pgsm_front.sv =====
module pgsm_front #(
  parameter int COORD_BITS = pgsm_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    take,
  input  logic signed [COORD_BITS-1:0]            point_x,
  input  logic signed [COORD_BITS-1:0]            point_y,
  input  logic signed [COORD_BITS-1:0]            point_z,
  input  logic                                    point_valid,
  input  logic                                    frame_last,
  input  logic signed [pgsm_pkg::NORMAL_BITS-1:0] normal_x,
  input  logic signed [pgsm_pkg::NORMAL_BITS-1:0] normal_y,
  input  logic signed [pgsm_pkg::NORMAL_BITS-1:0] normal_z,
  input  logic signed [pgsm_pkg::OFFSET_BITS-1:0] plane_offset,
  output logic                                    item_valid,
  output logic signed [COORD_BITS-1:0]            item_z,
  output pgsm_pkg::flags_t                        item_flags
);

  localparam int PROD_W = COORD_BITS + pgsm_pkg::NORMAL_BITS;
  // three products plus headroom, never narrower than the offset plus sign
  localparam int SUM_W  = PROD_W + 2;
  localparam int DOT_W  = (SUM_W > pgsm_pkg::OFFSET_BITS + 1) ? SUM_W
                                                              : pgsm_pkg::OFFSET_BITS + 1;

  // stage 1: products
  logic                         s1_vld;
  logic signed [PROD_W-1:0]     prod_x;
  logic signed [PROD_W-1:0]     prod_y;
  logic signed [PROD_W-1:0]     prod_z;
  logic signed [COORD_BITS-1:0] s1_z;
  logic                         s1_cand;
  logic                         s1_last;

  // stage 2: plane test result
  logic                         s2_vld;
  logic signed [COORD_BITS-1:0] s2_z;
  pgsm_pkg::flags_t             s2_flags;

  logic signed [DOT_W-1:0]      dot;
  logic signed [DOT_W-1:0]      offset_ext;
  logic                         above;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= take;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prod_x  <= PROD_W'(normal_x) * PROD_W'(point_x);
      prod_y  <= PROD_W'(normal_y) * PROD_W'(point_y);
      prod_z  <= PROD_W'(normal_z) * PROD_W'(point_z);
      s1_z    <= point_z;
      s1_cand <= point_valid && (point_z != '0);
      s1_last <= frame_last;
    end
  end

  assign dot        = DOT_W'(prod_x) + DOT_W'(prod_y) + DOT_W'(prod_z);
  assign offset_ext = DOT_W'(plane_offset);
  assign above      = (dot > offset_ext);

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      s2_z          <= s1_z;
      s2_flags.kept <= s1_cand && above;
      s2_flags.last <= s1_last;
    end
  end

  assign item_valid = s2_vld;
  assign item_z     = s2_z;
  assign item_flags = s2_flags;

endmodule

// ===== hw/rtl/pgsm_back.sv =====
module pgsm_back #(
  parameter int COORD_BITS = pgsm_pkg::COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic signed [COORD_BITS-1:0] item_z,
  input  pgsm_pkg::flags_t             item_flags,
  input  logic                         res_ready,
  output logic                         item_take,
  output logic                         res_push,
  output logic signed [COORD_BITS-1:0] res_distance,
  output logic                         res_no_reading
);

  logic signed [COORD_BITS-1:0] smallest_depth;
  logic signed [COORD_BITS-1:0] second_depth;
  pgsm_pkg::count_t             kept_count;
  pgsm_pkg::count_t             point_count;

  logic signed [COORD_BITS-1:0] smallest_next;
  logic signed [COORD_BITS-1:0] second_next;
  pgsm_pkg::count_t             kept_next;
  pgsm_pkg::count_t             point_next;

  // a frame end needs room for its result
  assign item_take = item_valid && (!item_flags.last || res_ready);

  always_comb begin
    smallest_next = smallest_depth;
    second_next   = second_depth;
    kept_next     = kept_count;
    point_next    = (point_count == pgsm_pkg::COUNT_SAT) ? point_count
                                                          : point_count + pgsm_pkg::COUNT_ONE;
    if (item_flags.kept) begin
      priority if (kept_count == pgsm_pkg::COUNT_ZERO) begin
        smallest_next = item_z;
        kept_next     = pgsm_pkg::COUNT_ONE;
      end else if (kept_count == pgsm_pkg::COUNT_ONE) begin
        if (item_z < smallest_depth) begin
          second_next   = smallest_depth;
          smallest_next = item_z;
        end else begin
          second_next = item_z;
        end
        kept_next = pgsm_pkg::COUNT_SAT;
      end else begin
        if (item_z < smallest_depth) begin
          second_next   = smallest_depth;
          smallest_next = item_z;
        end else if (item_z < second_depth) begin
          second_next = item_z;
        end
      end
    end
  end

  assign res_push       = item_take && item_flags.last;
  assign res_no_reading = (point_next != pgsm_pkg::COUNT_SAT) ||
                          (kept_next != pgsm_pkg::COUNT_SAT);
  assign res_distance   = res_no_reading ? '0 : second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      smallest_depth <= '0;
      second_depth   <= '0;
      kept_count     <= pgsm_pkg::COUNT_ZERO;
      point_count    <= pgsm_pkg::COUNT_ZERO;
    end else if (item_take) begin
      if (item_flags.last) begin
        smallest_depth <= '0;
        second_depth   <= '0;
        kept_count     <= pgsm_pkg::COUNT_ZERO;
        point_count    <= pgsm_pkg::COUNT_ZERO;
      end else begin
        smallest_depth <= smallest_next;
        second_depth   <= second_next;
        kept_count     <= kept_next;
        point_count    <= point_next;
      end
    end
  end

endmodule

// ===== hw/rtl/plane_gated_second_min_range.sv =====
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------------------
// points    | push / full                | point_x, point_y, point_z, point_valid, frame_last
// results   | empty / pop                | distance, no_reading
// config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One point per cycle sustained while the result queue has room. A point runs
// through a two-stage classifier (three multiplies, then the sum and plane
// compare), a four-entry queue and a two-minimum tracker; the result is queued
// when the tracker takes the frame's last point. Sync active-high reset clears
// all control state and loads the register defaults (normal = +z). The classifier
// never stalls: full is raised from a credit count covering its stages and the
// queue. A full result queue stalls only the tracker on frame ends.
module plane_gated_second_min_range #(
  parameter int COORD_BITS = pgsm_pkg::COORD_BITS_DEFAULT,
  parameter int MID_DEPTH  = pgsm_pkg::MID_DEPTH_DEFAULT,
  parameter int OUT_DEPTH  = pgsm_pkg::OUT_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // points
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [COORD_BITS-1:0]         point_x,
  input  logic signed [COORD_BITS-1:0]         point_y,
  input  logic signed [COORD_BITS-1:0]         point_z,
  input  logic                                 point_valid,
  input  logic                                 frame_last,
  // results
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [COORD_BITS-1:0]         distance,
  output logic                                 no_reading,
  // config writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pgsm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pgsm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int MID_W    = COORD_BITS + pgsm_pkg::FLAGS_BITS;
  localparam int OUT_W    = COORD_BITS + 1;
  localparam int CREDIT_W = $clog2(MID_DEPTH + 1);
  localparam logic [CREDIT_W-1:0] CREDIT_MAX = CREDIT_W'(MID_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers; cfg_ready is always high, so writes are never held off
  // ---------------------------------------------------------------------------
  logic signed [pgsm_pkg::NORMAL_BITS-1:0] normal_x;
  logic signed [pgsm_pkg::NORMAL_BITS-1:0] normal_y;
  logic signed [pgsm_pkg::NORMAL_BITS-1:0] normal_z;
  logic signed [pgsm_pkg::OFFSET_BITS-1:0] plane_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x     <= '0;
      normal_y     <= '0;
      normal_z     <= pgsm_pkg::NORMAL_Z_RESET;
      plane_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pgsm_pkg::REG_NORMAL_X:     normal_x     <= cfg_data[pgsm_pkg::NORMAL_BITS-1:0];
        pgsm_pkg::REG_NORMAL_Y:     normal_y     <= cfg_data[pgsm_pkg::NORMAL_BITS-1:0];
        pgsm_pkg::REG_NORMAL_Z:     normal_z     <= cfg_data[pgsm_pkg::NORMAL_BITS-1:0];
        pgsm_pkg::REG_PLANE_OFFSET: plane_offset <= cfg_data;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input acceptance with credits: one credit per item in the classifier
  // stages or the middle queue, so the queue can never overflow.
  // ---------------------------------------------------------------------------
  logic                in_take;
  logic [CREDIT_W-1:0] credit;
  logic                mid_pop;

  assign full    = (credit == CREDIT_MAX);
  assign in_take = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else if (in_take && !mid_pop) begin
      credit <= credit + CREDIT_W'(1);
    end else if (mid_pop && !in_take) begin
      credit <= credit - CREDIT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Front: plane test and classification
  // ---------------------------------------------------------------------------
  logic                         fr_valid;
  logic signed [COORD_BITS-1:0] fr_z;
  pgsm_pkg::flags_t             fr_flags;

  pgsm_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (in_take),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .point_valid  (point_valid),
    .frame_last   (frame_last),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .plane_offset (plane_offset),
    .item_valid   (fr_valid),
    .item_z       (fr_z),
    .item_flags   (fr_flags)
  );

  // ---------------------------------------------------------------------------
  // Middle queue: classified depths waiting for the tracker
  // ---------------------------------------------------------------------------
  logic [MID_W-1:0]             mid_rdata;
  logic                         mid_empty;
  logic                         mid_full;
  logic signed [COORD_BITS-1:0] bk_z;
  pgsm_pkg::flags_t             bk_flags;

  pgsm_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fr_valid),
    .wdata ({fr_z, fr_flags}),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .full  (mid_full)
  );

  assign bk_z     = mid_rdata[MID_W-1:pgsm_pkg::FLAGS_BITS];
  assign bk_flags = mid_rdata[pgsm_pkg::FLAGS_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Back: running two-minimum tracker, emits on frame end
  // ---------------------------------------------------------------------------
  logic                         res_push;
  logic signed [COORD_BITS-1:0] res_distance;
  logic                         res_no_reading;
  logic                         out_full;

  pgsm_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (!mid_empty),
    .item_z         (bk_z),
    .item_flags     (bk_flags),
    .res_ready      (!out_full),
    .item_take      (mid_pop),
    .res_push       (res_push),
    .res_distance   (res_distance),
    .res_no_reading (res_no_reading)
  );

  // ---------------------------------------------------------------------------
  // Result queue: parts the tracker from the consumer
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0] out_rdata;

  pgsm_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata ({res_distance, res_no_reading}),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .full  (out_full)
  );

  assign distance   = out_rdata[OUT_W-1:1];
  assign no_reading = out_rdata[0];

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // credits bound the items in flight
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= CREDIT_MAX)
    else $error("credit count above queue depth");

  // the classifier never delivers into a full middle queue
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fr_valid |-> !mid_full)
    else $error("middle queue overflow");

  // a tracker result is only produced when the result queue has room
  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_full)
    else $error("result queue overflow");

  // a no-reading result carries a zero distance
  a_no_reading_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && no_reading) |-> (distance == '0))
    else $error("no-reading result with nonzero distance");
`endif

endmodule

// ===== tb/second_min_checker.sv =====
`timescale 1ns / 1ps

module second_min_checker
  import pgsm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  input  logic signed [COORD_BITS-1:0]  point_z,
  input  logic                          point_valid,
  input  logic                          frame_last,
  input  logic                          empty,
  input  logic                          pop,
  input  logic signed [COORD_BITS-1:0]  distance,
  input  logic                          no_reading,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  output int                            errors,
  output int                            pending
);

  typedef struct packed {
    logic [COORD_BITS-1:0] distance;
    logic                  no_reading;
  } range_t;

  range_t expected_ranges[$];

  // plane registers
  logic signed [NORMAL_BITS-1:0] plane_nx, plane_ny, plane_nz;
  logic signed [OFFSET_BITS-1:0] plane_offset;

  // per-frame tracker
  logic signed [COORD_BITS-1:0] low_depth, next_depth;
  count_t kept_seen, points_seen;

  task automatic clear_frame();
    low_depth   = '0;
    next_depth  = '0;
    kept_seen   = COUNT_ZERO;
    points_seen = COUNT_ZERO;
  endtask

  task automatic apply_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_NORMAL_X:     plane_nx = data[NORMAL_BITS-1:0];
      REG_NORMAL_Y:     plane_ny = data[NORMAL_BITS-1:0];
      REG_NORMAL_Z:     plane_nz = data[NORMAL_BITS-1:0];
      REG_PLANE_OFFSET: plane_offset = data[OFFSET_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic track_point();
    longint dot;
    logic   kept;
    range_t r;
    dot = longint'(plane_nx) * longint'(point_x) + longint'(plane_ny) * longint'(point_y)
        + longint'(plane_nz) * longint'(point_z);
    kept = point_valid && (point_z != 0) && (dot > longint'(plane_offset));
    if (points_seen != COUNT_SAT) points_seen = points_seen + COUNT_ONE;
    if (kept) begin
      case (kept_seen)
        COUNT_ZERO: begin
          low_depth = point_z;
          kept_seen = COUNT_ONE;
        end
        COUNT_ONE: begin
          if (point_z < low_depth) begin
            next_depth = low_depth;
            low_depth  = point_z;
          end else begin
            next_depth = point_z;
          end
          kept_seen = COUNT_SAT;
        end
        default: begin
          if (point_z < low_depth) begin
            next_depth = low_depth;
            low_depth  = point_z;
          end else if (point_z < next_depth) begin
            next_depth = point_z;
          end
        end
      endcase
    end
    if (frame_last) begin
      if (points_seen != COUNT_SAT || kept_seen != COUNT_SAT) begin
        r.distance   = '0;
        r.no_reading = 1'b1;
      end else begin
        r.distance   = next_depth;
        r.no_reading = 1'b0;
      end
      expected_ranges = {expected_ranges, r};
      clear_frame();
    end
  endtask

  task automatic check_result();
    range_t r;
    if (expected_ranges.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got distance %0d no_reading %0b",
               $time, distance, no_reading);
    end else begin
      r = expected_ranges.pop_front();
      if (distance !== r.distance) begin
        errors++;
        $display("%0t: distance expected %0d got %0d", $time, $signed(r.distance), distance);
      end
      if (no_reading !== r.no_reading) begin
        errors++;
        $display("%0t: no_reading expected %0b got %0b", $time, r.no_reading, no_reading);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      plane_nx     = '0;
      plane_ny     = '0;
      plane_nz     = NORMAL_Z_RESET;
      plane_offset = '0;
      clear_frame();
      expected_ranges.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (push && !full) track_point();
      if (pop && !empty) check_result();
    end
    pending = expected_ranges.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pgsm_pkg::*;

  localparam int CW           = COORD_BITS_DEFAULT;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;       // lets in-flight points drain after the last result
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 68;

  // indexes outside the register map; writes there must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED  = 8'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_TOP = 8'hFF;

  localparam logic signed [NORMAL_BITS-1:0] NORMAL_ONE       = 16'sd16384;
  localparam logic signed [NORMAL_BITS-1:0] NORMAL_MINUS_ONE = -16'sd16384;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MIN = 32'h8000_0000;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = 32'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 push = 1'b0;
  logic                 full;
  logic signed [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic                 point_valid = 1'b0, frame_last = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic signed [CW-1:0] distance;
  logic                 no_reading;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

  int errors;
  int pending;
  int cycles = 0;
  int items_sent = 0;
  int push_idle_pct = 15;   // odds in percent that an idle burst precedes a point
  int pop_idle_pct = 15;    // odds in percent that the result side stalls
  int pop_hold = 0;

  always #2 clk = ~clk;

  plane_gated_second_min_range dut (.*);

  second_min_checker #(.COORD_BITS(CW)) u_range_chk (.*);

  // Result side: sometimes stall for a random burst, otherwise keep pop high.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold = pop_hold - 1;
      pop <= 1'b0;
    end else if ($urandom_range(0, 99) < pop_idle_pct) begin
      pop_hold = $urandom_range(0, 2);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // One point; push stays high on return so back-to-back items need no toggle.
  task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                            input logic signed [CW-1:0] z, input logic valid,
                            input logic last);
    if (push_idle_pct > 0 && $urandom_range(0, 99) < push_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push        <= 1'b1;
    point_x     <= x;
    point_y     <= y;
    point_z     <= z;
    point_valid <= valid;
    frame_last  <= last;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Wait until every frame result is out, then let in-flight points drain.
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // All four registers, then two writes that must not land anywhere.
  task automatic program_plane(input logic [CFG_DATA_BITS-1:0] nx,
                               input logic [CFG_DATA_BITS-1:0] ny,
                               input logic [CFG_DATA_BITS-1:0] nz,
                               input logic [CFG_DATA_BITS-1:0] offset);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_PLANE_OFFSET, offset);
    write_reg(REG_UNMAPPED, $urandom);
    write_reg(REG_INDEX_TOP, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] rand_normal();
    int n;
    n = int'($urandom_range(0, 32768)) - 16384;
    return CFG_DATA_BITS'(n);
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] extreme_normal();
    case ($urandom_range(0, 2))
      0:       return CFG_DATA_BITS'(NORMAL_ONE);
      1:       return CFG_DATA_BITS'(NORMAL_MINUS_ONE);
      default: return '0;
    endcase
  endfunction

  // Depths lean on a small pool so ties and reorderings are common.
  function automatic logic signed [CW-1:0] random_depth();
    logic signed [CW-1:0] z;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: z = CW'($urandom_range(1, 8) * 50);
      5:             z = -CW'($urandom_range(1, 8) * 50);
      6:             z = '0;
      7:             z = CW'($urandom);
      8:             z = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default:       z = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
    endcase
    return z;
  endfunction

  // Mostly 2..6 points; some single-point frames and some long ones.
  task automatic send_frame();
    int n;
    case ($urandom_range(0, 9))
      0:       n = 1;
      1:       n = $urandom_range(7, 12);
      default: n = $urandom_range(2, 6);
    endcase
    for (int i = 0; i < n; i++) begin
      send_point(CW'($urandom), CW'($urandom), random_depth(),
                 $urandom_range(0, 9) != 0, i == n - 1);
    end
  endtask

  initial begin
    int goal;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset plane is z > 0: kept means valid, positive depth.
    send_point(0, 0, 100, 1'b1, 1'b1);                // lone point: no reading
    send_point(0, 0, 500, 1'b1, 1'b0);
    send_point(0, 0, 300, 1'b1, 1'b0);                // new smallest pushes 500 down
    send_point(0, 0, 700, 1'b1, 1'b1);
    send_point(0, 0, 42, 1'b1, 1'b0);                 // tie: 42 twice gives 42
    send_point(0, 0, 42, 1'b1, 1'b1);
    send_point(0, 0, 10, 1'b0, 1'b0);                 // NaN point dropped
    send_point(0, 0, 20, 1'b1, 1'b1);                 // one kept: no reading
    send_point(0, 0, 0, 1'b1, 1'b0);                  // zero depth dropped
    send_point(0, 0, 5, 1'b1, 1'b0);
    send_point(0, 0, 6, 1'b1, 1'b1);
    send_point(-16'sd32768, 16'sd32767, 16'sd32767, 1'b1, 1'b0);
    send_point(16'sd32767, -16'sd32768, 1, 1'b1, 1'b1);
    send_point(0, 0, -3, 1'b1, 1'b0);                 // below the plane
    send_point(0, 0, 4, 1'b1, 1'b0);
    send_point(0, 0, 9, 1'b1, 1'b1);

    // Flipped normal keeps negative depths, compared signed.
    settle();
    program_plane('0, '0, CFG_DATA_BITS'(NORMAL_MINUS_ONE), '0);
    send_point(0, 0, -5, 1'b1, 1'b0);
    send_point(0, 0, -9, 1'b1, 1'b0);
    send_point(0, 0, -9, 1'b1, 1'b1);
    send_point(0, 0, -16'sd32768, 1'b1, 1'b0);
    send_point(0, 0, -1, 1'b1, 1'b0);
    send_point(0, 0, 7, 1'b1, 1'b0);
    send_point(0, 0, -16'sd32767, 1'b1, 1'b1);

    // Random phases; the first two pin the offset extremes.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) begin
        program_plane(CFG_DATA_BITS'(NORMAL_ONE), CFG_DATA_BITS'(NORMAL_MINUS_ONE),
                      CFG_DATA_BITS'(NORMAL_ONE), OFFSET_MIN);
      end else if (p == 1) begin
        program_plane(CFG_DATA_BITS'(NORMAL_MINUS_ONE), CFG_DATA_BITS'(NORMAL_ONE),
                      CFG_DATA_BITS'(NORMAL_MINUS_ONE), OFFSET_MAX);
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            case ($urandom_range(0, 3))
              0:       goal = int'(OFFSET_MIN);
              1:       goal = int'(OFFSET_MAX);
              2:       goal = 0;
              default: goal = -1;
            endcase
            program_plane(extreme_normal(), extreme_normal(), extreme_normal(),
                          CFG_DATA_BITS'(goal));
          end
          4: program_plane($urandom, $urandom, $urandom, $urandom);
          default: begin
            // small offset: roughly half the points land above the plane
            goal = int'($urandom_range(0, 1 << 23)) - (1 << 22);
            program_plane(rand_normal(), rand_normal(), rand_normal(), CFG_DATA_BITS'(goal));
          end
        endcase
      end

      // last phase runs at full rate on both sides
      if (p == PHASES - 1) begin
        push_idle_pct = 0;
        pop_idle_pct  = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       push_idle_pct = 0;
          1:       push_idle_pct = 15;
          default: push_idle_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       pop_idle_pct = 0;
          1:       pop_idle_pct = 15;
          default: pop_idle_pct = 40;
        endcase
      end

      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) send_frame();
    end

    settle();
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pgsm_pkg.sv
hw/rtl/pgsm_fifo.sv
hw/rtl/pgsm_front.sv
hw/rtl/pgsm_back.sv
hw/rtl/plane_gated_second_min_range.sv
tb/second_min_checker.sv
tb/tb_top.sv
